// ===== design/rllp_pkg.sv =====
`timescale 1ns / 1ps

package rllp_pkg;

    // Q15 fraction bits and register width
    localparam int FRAC  = 15;
    localparam int CFG_W = 15;
    // width of every coefficient-path product slice
    localparam int COEF_W = 18;

    localparam logic [CFG_W-1:0]  ONE_Q15          = 15'h7fff;
    localparam logic [CFG_W-1:0]  C_POINT_EIGHT    = 15'h6666;
    localparam logic [CFG_W-1:0]  C_SIXTH          = 15'h1555;
    localparam logic [COEF_W-1:0] C_FIVE_POINT_SIX = 18'h2cccc;

    // configuration register index
    typedef enum logic [0:0] {
        REG_CUTOFF    = 1'b0,
        REG_RESONANCE = 1'b1
    } cfg_reg_t;

    // one multiply of the micro program, in execution order
    typedef enum logic [4:0] {
        OP_T0    = 5'd0,   // 0.8 * cutoff
        OP_T1    = 5'd1,   // * (1 - cutoff), gives p and f
        OP_SQ0   = 5'd2,   // (1 - cutoff)^2
        OP_SQ1   = 5'd3,   // * 5.6, gives inner term
        OP_G     = 5'd4,   // inner * (1 - cutoff), gives g
        OP_Q     = 5'd5,   // resonance * g, gives q
        OP_FB    = 5'd6,   // q * stage four, feedback
        OP_S1P   = 5'd7,
        OP_S1F   = 5'd8,
        OP_S2P   = 5'd9,
        OP_S2F   = 5'd10,
        OP_S3P   = 5'd11,
        OP_S3F   = 5'd12,
        OP_S4P   = 5'd13,
        OP_S4F   = 5'd14,
        OP_CUBE0 = 5'd15,  // s4 * s4
        OP_CUBE1 = 5'd16,  // * s4
        OP_CLIP  = 5'd17   // * 1/6, soft clip
    } op_t;

    // sequencer controls toward the datapath
    typedef struct packed {
        logic start;
        logic wb;
        logic load_out;
        op_t  op;
    } seq_ctl_t;

endpackage

// ===== design/resonant_ladder_lowpass_q15_top.sv =====
`timescale 1ns / 1ps
// One word at a time: s_tready stays low from a taken word until its result is loaded into
//   the output register; twelve multiplies run one after another on one bit-serial multiplier.
// A register write forces a coefficient refresh before the next word is taken.
// Reset (aresetn low, synchronous) clears the filter state, loads the register defaults
//   and runs the coefficient refresh before s_tready rises.
module resonant_ladder_lowpass_q15_top #(
    parameter  int SAMPLE_WIDTH = 16,
    localparam int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_addr,
    input  logic [rllp_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [DATA_W-1:0]          s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [DATA_W-1:0]          m_tdata    // [SAMPLE_WIDTH-1:0] sample_out
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int EXT = 3;
    localparam int AW  = W + EXT;
    localparam int PW  = AW + W;
    localparam int FR  = rllp_pkg::FRAC;
    localparam int CW  = rllp_pkg::CFG_W;
    localparam int KW  = rllp_pkg::COEF_W;

    rllp_pkg::seq_ctl_t ctl;

    logic          mul_done;
    logic [PW-1:0] prod;
    logic [AW-1:0] a_opnd;
    logic [W-1:0]  b_opnd;
    logic          out_free;
    logic          take_in;

    logic [CW-1:0] cutoff_reg, cutoff_next;
    logic [CW-1:0] res_reg, res_next;
    logic [W-1:0]  p_reg, p_next;
    logic [W-1:0]  f_reg, f_next;
    logic [AW-1:0] q_reg, q_next;
    logic [AW-1:0] tmp_reg, tmp_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  prev_reg, prev_next;
    logic [W-1:0]  s1_reg, s1_next;
    logic [W-1:0]  s2_reg, s2_next;
    logic [W-1:0]  s3_reg, s3_next;
    logic [W-1:0]  s4_reg, s4_next;
    logic [DATA_W-1:0] out_reg, out_next;
    logic          ovalid_reg, ovalid_next;

    logic [CW-1:0] qc;
    logic [W-1:0]  rw;
    logic [KW-1:0] cr;
    logic [W-1:0]  psum;
    logic [KW:0]   inner;
    logic [KW-1:0] gain;
    logic [W-1:0]  fb_u;
    logic [W-1:0]  diff;
    logic [W-1:0]  tmp_w;
    logic [W-1:0]  link;

    rllp_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .mul_done (mul_done),
        .out_free (out_free),
        .s_tready (s_tready),
        .ctl      (ctl)
    );

    rllp_mul #(
        .AW (AW),
        .BW (W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.start),
        .a       (a_opnd),
        .b       (b_opnd),
        .done    (mul_done),
        .prod    (prod)
    );

    assign out_free = !ovalid_reg || m_tready;
    assign take_in  = s_tvalid && s_tready;

    // product slices: wrapped sample value and coefficient value
    assign qc    = rllp_pkg::ONE_Q15 - cutoff_reg;
    assign rw    = prod[FR +: W];
    assign cr    = prod[FR +: KW];
    assign tmp_w = tmp_reg[W-1:0];

    // pick the multiplier operands for the current op
    always_comb begin
        a_opnd = tmp_reg;
        b_opnd = tmp_w;
        unique case (ctl.op)
            rllp_pkg::OP_T0: begin
                a_opnd = AW'(rllp_pkg::C_POINT_EIGHT);
                b_opnd = W'(cutoff_reg);
            end
            rllp_pkg::OP_T1, rllp_pkg::OP_G: begin
                a_opnd = tmp_reg;
                b_opnd = W'(qc);
            end
            rllp_pkg::OP_SQ0: begin
                a_opnd = AW'(qc);
                b_opnd = W'(qc);
            end
            rllp_pkg::OP_SQ1: begin
                a_opnd = AW'(rllp_pkg::C_FIVE_POINT_SIX);
                b_opnd = tmp_w;
            end
            rllp_pkg::OP_Q: begin
                a_opnd = tmp_reg;
                b_opnd = W'(res_reg);
            end
            rllp_pkg::OP_FB: begin
                a_opnd = q_reg;
                b_opnd = s4_reg;
            end
            rllp_pkg::OP_S1P, rllp_pkg::OP_S2P, rllp_pkg::OP_S3P, rllp_pkg::OP_S4P: begin
                a_opnd = {{EXT{tmp_w[W-1]}}, tmp_w};
                b_opnd = p_reg;
            end
            rllp_pkg::OP_S1F: begin
                a_opnd = {{EXT{s1_reg[W-1]}}, s1_reg};
                b_opnd = f_reg;
            end
            rllp_pkg::OP_S2F: begin
                a_opnd = {{EXT{s2_reg[W-1]}}, s2_reg};
                b_opnd = f_reg;
            end
            rllp_pkg::OP_S3F: begin
                a_opnd = {{EXT{s3_reg[W-1]}}, s3_reg};
                b_opnd = f_reg;
            end
            rllp_pkg::OP_S4F: begin
                a_opnd = {{EXT{s4_reg[W-1]}}, s4_reg};
                b_opnd = f_reg;
            end
            rllp_pkg::OP_CUBE0: begin
                a_opnd = {{EXT{s4_reg[W-1]}}, s4_reg};
                b_opnd = s4_reg;
            end
            rllp_pkg::OP_CUBE1: begin
                a_opnd = {{EXT{tmp_w[W-1]}}, tmp_w};
                b_opnd = s4_reg;
            end
            rllp_pkg::OP_CLIP: begin
                a_opnd = AW'(rllp_pkg::C_SIXTH);
                b_opnd = tmp_w;
            end
            default: begin
                a_opnd = tmp_reg;
                b_opnd = tmp_w;
            end
        endcase
    end

    // write back the product of the finished op
    always_comb begin
        cutoff_next = cutoff_reg;
        res_next    = res_reg;
        p_next      = p_reg;
        f_next      = f_reg;
        q_next      = q_reg;
        tmp_next    = tmp_reg;
        x_next      = x_reg;
        prev_next   = prev_reg;
        s1_next     = s1_reg;
        s2_next     = s2_reg;
        s3_next     = s3_reg;
        s4_next     = s4_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;

        psum  = W'(cutoff_reg) + W'(cr);
        inner = (KW+1)'(rllp_pkg::ONE_Q15) - (KW+1)'(qc) + (KW+1)'(cr);
        gain  = KW'(rllp_pkg::ONE_Q15) + KW'(cr[KW-1:1]);
        fb_u  = x_reg - rw;
        diff  = tmp_w - rw;
        link  = '0;

        if (cfg_we) begin
            unique case (rllp_pkg::cfg_reg_t'(cfg_addr))
                rllp_pkg::REG_CUTOFF:    cutoff_next = cfg_wdata;
                rllp_pkg::REG_RESONANCE: res_next    = cfg_wdata;
                default: begin
                end
            endcase
        end

        if (take_in) begin
            x_next = s_tdata[W-1:0];
        end

        if (ctl.wb) begin
            unique case (ctl.op)
                rllp_pkg::OP_T0, rllp_pkg::OP_SQ0: begin
                    tmp_next = AW'(cr);
                end
                rllp_pkg::OP_T1: begin
                    p_next = psum;
                    f_next = {psum[W-2:0], 1'b0} - W'(rllp_pkg::ONE_Q15);
                end
                rllp_pkg::OP_SQ1: begin
                    tmp_next = AW'(inner);
                end
                rllp_pkg::OP_G: begin
                    tmp_next = AW'(gain);
                end
                rllp_pkg::OP_Q: begin
                    q_next = AW'(cr);
                end
                rllp_pkg::OP_FB: begin
                    // feedback subtracted, then summed with the last feedback-subtracted input
                    prev_next = fb_u;
                    link      = fb_u + prev_reg;
                    tmp_next  = {{EXT{link[W-1]}}, link};
                end
                rllp_pkg::OP_S1P, rllp_pkg::OP_S2P, rllp_pkg::OP_S3P, rllp_pkg::OP_S4P,
                rllp_pkg::OP_CUBE0, rllp_pkg::OP_CUBE1: begin
                    tmp_next = {{EXT{rw[W-1]}}, rw};
                end
                rllp_pkg::OP_S1F: begin
                    s1_next  = diff;
                    link     = diff + s1_reg;
                    tmp_next = {{EXT{link[W-1]}}, link};
                end
                rllp_pkg::OP_S2F: begin
                    s2_next  = diff;
                    link     = diff + s2_reg;
                    tmp_next = {{EXT{link[W-1]}}, link};
                end
                rllp_pkg::OP_S3F: begin
                    s3_next  = diff;
                    link     = diff + s3_reg;
                    tmp_next = {{EXT{link[W-1]}}, link};
                end
                rllp_pkg::OP_S4F: begin
                    s4_next = diff;
                end
                rllp_pkg::OP_CLIP: begin
                    s4_next = s4_reg - rw;
                end
                default: begin
                end
            endcase
        end

        // output register: load the clipped stage, drop once taken
        if (ctl.load_out) begin
            out_next    = DATA_W'(s4_reg);
            ovalid_next = 1'b1;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= 15'd16384;
            res_reg    <= '0;
            prev_reg   <= '0;
            s1_reg     <= '0;
            s2_reg     <= '0;
            s3_reg     <= '0;
            s4_reg     <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            cutoff_reg <= cutoff_next;
            res_reg    <= res_next;
            prev_reg   <= prev_next;
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            s4_reg     <= s4_next;
            ovalid_reg <= ovalid_next;
        end
        p_reg   <= p_next;
        f_reg   <= f_next;
        q_reg   <= q_next;
        tmp_reg <= tmp_next;
        x_reg   <= x_next;
        out_reg <= out_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== design/rllp_mul.sv =====
`timescale 1ns / 1ps

// Serial-parallel signed multiplier: one multiplier bit per cycle.
module rllp_mul #(
    parameter int AW = 19,
    parameter int BW = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);

    localparam int CW = $clog2(BW);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW:0]   hi_reg, hi_next;
    logic [BW-1:0] lo_reg, lo_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic          last;
    logic [AW:0]   a_ext;
    logic [AW:0]   addend;
    logic [AW:0]   sum;

    // add the multiplicand for each set bit, subtract it for the sign bit
    always_comb begin
        last   = (cnt_reg == CW'(BW - 1));
        a_ext  = {a_reg[AW-1], a_reg};
        addend = '0;
        if (lo_reg[0]) begin
            addend = last ? (~a_ext + 1'b1) : a_ext;
        end
        sum = hi_reg + addend;
    end

    // shift the partial product right one bit per step
    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            run_next = 1'b1;
            a_next   = a;
            hi_next  = '0;
            lo_next  = b;
            cnt_next = '0;
        end else if (run_reg) begin
            hi_next  = {sum[AW], sum[AW:1]};
            lo_next  = {sum[0], lo_reg[BW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        a_reg   <= a_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg[AW-1:0], lo_reg};

endmodule

// ===== design/rllp_seq.sv =====
`timescale 1ns / 1ps

// Micro sequencer: steps through the coefficient or sample program,
// one multiply at a time.
module rllp_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              s_tvalid,
    input  logic              mul_done,
    input  logic              out_free,
    output logic              s_tready,
    output rllp_pkg::seq_ctl_t ctl
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    rllp_pkg::op_t   op_reg, op_next;
    logic            dirty_reg, dirty_next;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        dirty_next  = dirty_reg;
        ctl         = '0;
        ctl.op      = op_reg;
        s_tready    = (state_reg == ST_IDLE) && !dirty_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // refresh coefficients first, then take a word
                if (dirty_reg) begin
                    op_next    = rllp_pkg::OP_T0;
                    dirty_next = 1'b0;
                    state_next = ST_START;
                end else if (s_tvalid) begin
                    op_next    = rllp_pkg::OP_FB;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                ctl.start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    ctl.wb = 1'b1;
                    if (op_reg == rllp_pkg::OP_Q) begin
                        state_next = ST_IDLE;
                    end else if (op_reg == rllp_pkg::OP_CLIP) begin
                        state_next = ST_OUT;
                    end else begin
                        op_next    = rllp_pkg::op_t'(op_reg + 5'd1);
                        state_next = ST_START;
                    end
                end
            end
            ST_OUT: begin
                // hold the result until the output register is free
                if (out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // any register write forces a coefficient refresh
        if (cfg_we) begin
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= rllp_pkg::OP_T0;
            dirty_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            dirty_reg <= dirty_next;
        end
    end

endmodule

// ===== design/rllp_chk.sv =====
`timescale 1ns / 1ps

module rllp_chk #(
    parameter  int SAMPLE_WIDTH = 16,
    localparam int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              cfg_we,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    // reset leaves no word out and refreshes coefficients before taking input
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output or input active right after reset");

    // one word in flight: input closes right after a word is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in work");

    // a register write blocks input until coefficients are refreshed
    a_cfg_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input ready right after a register write");

    // a result cannot appear in the cycle after its word is taken
    a_no_instant_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("output word appeared without computation");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

endmodule

bind resonant_ladder_lowpass_q15_top rllp_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rllp_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
